/* rtl/core/lrrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrq_pkg
// shared constants, codes and control types of the linear resampler ring queue
// ----------------------------------------------------------------------------
package lrrq_pkg;

    // sizing
    localparam int NUM_STREAMS       = 4;
    localparam int RING_SAMPLES      = 16384;
    localparam int MAX_BATCH_SAMPLES = 4096;

    // fixed field widths
    localparam int OP_W       = 3;
    localparam int STREAM_IN_W = 8;
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 16;
    localparam int RIDX_W     = 14;
    localparam int STATUS_W   = 2;
    localparam int QC_W       = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int RATE_W     = 18;
    localparam int CHAN_W     = 4;
    localparam int FACTOR_W   = 15;

    localparam int FACTOR_MIN = 14746;
    localparam int FACTOR_MAX = 18022;
    localparam int VOLUME_MAX = 32768;

    // derived widths
    localparam int STREAM_W    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int RING_AW     = $clog2(RING_SAMPLES);
    localparam int RING_MEM_AW = $clog2(NUM_STREAMS * RING_SAMPLES);
    localparam int COUNT_W     = RING_AW + 1;
    localparam int BATCH_AW    = $clog2(MAX_BATCH_SAMPLES);
    localparam int FILL_W      = BATCH_AW + 1;
    localparam int RATEP_W     = RATE_W + FACTOR_W + 2;
    localparam int STEP_W      = 32;
    localparam int DIV_NW      = 36;
    localparam int DIV_DW      = STEP_W;
    localparam int DIV_CNT_W   = $clog2(DIV_NW + 1);
    localparam int OF_W        = FILL_W + 17;
    localparam int TOT_W       = OF_W + CHAN_W;
    localparam int POS_W       = ((FILL_W + 16 > STEP_W) ? FILL_W + 16 : STEP_W) + 2;
    localparam int ADDR_PW     = BATCH_AW + CHAN_W;
    localparam int PROD_W      = 2 * SAMPLE_W + 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 3'd0,
        OP_RESET_ONE = 3'd1,
        OP_RESET_ALL = 3'd2,
        OP_SET_VOL   = 3'd3,
        OP_READ      = 3'd4
    } lrrq_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_RATE = 3'd0,
        CFG_OUT_RATE = 3'd1,
        CFG_SRC_CH   = 3'd2,
        CFG_OUT_CH   = 3'd3,
        CFG_FACTOR   = 3'd4
    } lrrq_cfg_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_TAKEN   = 2'd0,
        STS_QUEUED  = 2'd1,
        STS_INVALID = 2'd2,
        STS_FULL    = 2'd3
    } lrrq_status_t;

    typedef enum logic [1:0] {
        DIV_FRAMES = 2'd0,
        DIV_STEP   = 2'd1,
        DIV_OUT    = 2'd2
    } lrrq_div_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD_END,
        S_DIV_FRAMES,
        S_PROD,
        S_START_STEP,
        S_DIV_STEP,
        S_CHK_STEP,
        S_DIV_OUT,
        S_CHECK,
        S_RD_CUR,
        S_RD_NXT,
        S_MUL,
        S_WR,
        S_APPLY,
        S_FINISH
    } lrrq_state_t;

    typedef struct packed {
        logic          take;
        logic          batch_wr;
        logic          clr_one;
        logic          clr_all;
        logic          set_vol;
        logic          ring_rd;
        logic          div_start;
        lrrq_div_sel_t div_sel;
        logic          frames_ld;
        logic          prod_ld;
        logic          step_ld;
        logic          total_ld;
        logic          conv_init;
        logic          rd_cur;
        logic          rd_nxt;
        logic          mul;
        logic          wr;
        logic          commit;
        logic          status_we;
        lrrq_status_t  status;
        logic          finish;
    } lrrq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            last;
        logic            stream_ok;
        logic            cfg_bad;
        logic            div_busy;
        logic            frames_zero;
        logic            step_zero;
        logic            total_bad;
        logic            ring_full;
        logic            conv_last;
        logic            out_free;
    } lrrq_sts_t;

endpackage
`default_nettype wire

/* rtl/core/lrrq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrq channel interfaces
// item, result and configuration channels with valid / ready
// ----------------------------------------------------------------------------
interface lrrq_item_if;
    logic                                valid;
    logic                                ready;
    logic [lrrq_pkg::OP_W-1:0]           operation;
    logic [lrrq_pkg::STREAM_IN_W-1:0]    stream;
    logic signed [lrrq_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
    logic [lrrq_pkg::VOL_W-1:0]          volume_q15;
    logic [lrrq_pkg::RIDX_W-1:0]         ring_index;

    modport source (output valid, operation, stream, sample, last, volume_q15, ring_index,
                    input ready);
    modport sink (input valid, operation, stream, sample, last, volume_q15, ring_index,
                  output ready);
endinterface

interface lrrq_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [lrrq_pkg::STATUS_W-1:0]        status;
    logic [lrrq_pkg::QC_W-1:0]            queued_count;
    logic [lrrq_pkg::VOL_W-1:0]           stream_volume;
    logic signed [lrrq_pkg::SAMPLE_W-1:0] read_sample;

    modport source (output valid, status, queued_count, stream_volume, read_sample,
                    input ready);
    modport sink (input valid, status, queued_count, stream_volume, read_sample,
                  output ready);
endinterface

interface lrrq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lrrq_pkg::CFG_IDX_W-1:0]  index;
    logic [lrrq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/lrrq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lrrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/lrrq_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrq_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lrrq_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lrrq_pkg::DIV_NW-1:0] dividend,
    input  wire logic [lrrq_pkg::DIV_DW-1:0] divisor,
    output logic                             busy,
    output logic      [lrrq_pkg::DIV_NW-1:0] quotient
);
    import lrrq_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0]    rem_reg, rem_next;
    logic [DIV_NW-1:0]    quo_reg, quo_next;
    logic [DIV_DW-1:0]    dvs_reg, dvs_next;
    logic [DIV_DW:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_NW);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? DIV_DW'(trial - {1'b0, dvs_reg}) : trial[DIV_DW-1:0];
            quo_next = {quo_reg[DIV_NW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

/* rtl/core/lrrq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrq_ctrl
// sequencer: decodes items, runs batch checks and the resampling loop
// ----------------------------------------------------------------------------
module lrrq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lrrq_pkg::lrrq_sts_t sts,
    output lrrq_pkg::lrrq_cmd_t      cmd
);
    import lrrq_pkg::*;

    lrrq_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (in_valid) state_next = S_DECODE;
            S_DECODE:     state_next = (sts.op == OP_LOAD) ? S_LOAD_END : S_FINISH;
            S_LOAD_END:
            begin
                if (!sts.last || sts.cfg_bad) state_next = S_FINISH;
                else state_next = S_DIV_FRAMES;
            end
            S_DIV_FRAMES: if (!sts.div_busy) state_next = S_PROD;
            S_PROD:       state_next = sts.frames_zero ? S_FINISH : S_START_STEP;
            S_START_STEP: state_next = S_DIV_STEP;
            S_DIV_STEP:   if (!sts.div_busy) state_next = S_CHK_STEP;
            S_CHK_STEP:   state_next = sts.step_zero ? S_FINISH : S_DIV_OUT;
            S_DIV_OUT:    if (!sts.div_busy) state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.total_bad || sts.ring_full) state_next = S_FINISH;
                else state_next = S_RD_CUR;
            end
            S_RD_CUR:     state_next = S_RD_NXT;
            S_RD_NXT:     state_next = S_MUL;
            S_MUL:        state_next = S_WR;
            S_WR:         state_next = sts.conv_last ? S_APPLY : S_RD_CUR;
            S_APPLY:      state_next = S_FINISH;
            S_FINISH:     if (sts.out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_DECODE:
            begin
                cmd.status_we = 1'b1;
                cmd.status    = STS_TAKEN;
                case (sts.op)
                    OP_LOAD:      cmd.batch_wr = 1'b1;
                    OP_RESET_ONE:
                    begin
                        cmd.clr_one = sts.stream_ok;
                        if (!sts.stream_ok) cmd.status = STS_INVALID;
                    end
                    OP_RESET_ALL: cmd.clr_all = 1'b1;
                    OP_SET_VOL:
                    begin
                        cmd.set_vol = sts.stream_ok;
                        if (!sts.stream_ok) cmd.status = STS_INVALID;
                    end
                    OP_READ:
                    begin
                        cmd.ring_rd = sts.stream_ok;
                        if (!sts.stream_ok) cmd.status = STS_INVALID;
                    end
                    default:      cmd.status = STS_INVALID;
                endcase
            end
            S_LOAD_END:
            begin
                if (sts.last && sts.cfg_bad)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STS_INVALID;
                end
                else if (sts.last)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_FRAMES;
                end
            end
            S_DIV_FRAMES: cmd.frames_ld = !sts.div_busy;
            S_PROD:
            begin
                cmd.prod_ld   = 1'b1;
                cmd.status_we = sts.frames_zero;
                cmd.status    = STS_INVALID;
            end
            S_START_STEP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STEP;
            end
            S_DIV_STEP:   cmd.step_ld = !sts.div_busy;
            S_CHK_STEP:
            begin
                cmd.status_we = sts.step_zero;
                cmd.status    = STS_INVALID;
                cmd.div_start = !sts.step_zero;
                cmd.div_sel   = DIV_OUT;
            end
            S_DIV_OUT:    cmd.total_ld = !sts.div_busy;
            S_CHECK:
            begin
                cmd.status_we = sts.total_bad || sts.ring_full;
                cmd.status    = sts.total_bad ? STS_INVALID : STS_FULL;
                cmd.conv_init = !(sts.total_bad || sts.ring_full);
            end
            S_RD_CUR:     cmd.rd_cur = 1'b1;
            S_RD_NXT:     cmd.rd_nxt = 1'b1;
            S_MUL:        cmd.mul = 1'b1;
            S_WR:         cmd.wr = 1'b1;
            S_APPLY:
            begin
                cmd.commit    = 1'b1;
                cmd.status_we = 1'b1;
                cmd.status    = STS_QUEUED;
            end
            S_FINISH:     cmd.finish = 1'b1;
            default:      cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/lrrq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrrq_dp
// datapath: config, batch store, divider, interpolator, rings and result
// ----------------------------------------------------------------------------
module lrrq_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lrrq_pkg::lrrq_cmd_t                  cmd,
    output lrrq_pkg::lrrq_sts_t                       sts,
    input  wire logic                                 cfg_we,
    input  wire logic [lrrq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lrrq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [lrrq_pkg::OP_W-1:0]            operation,
    input  wire logic [lrrq_pkg::STREAM_IN_W-1:0]     stream,
    input  wire logic signed [lrrq_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                 last,
    input  wire logic [lrrq_pkg::VOL_W-1:0]           volume_q15,
    input  wire logic [lrrq_pkg::RIDX_W-1:0]          ring_index,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [lrrq_pkg::STATUS_W-1:0]             status,
    output logic [lrrq_pkg::QC_W-1:0]                 queued_count,
    output logic [lrrq_pkg::VOL_W-1:0]                stream_volume,
    output logic signed [lrrq_pkg::SAMPLE_W-1:0]      read_sample
);
    import lrrq_pkg::*;

    // configuration registers
    logic [RATE_W-1:0]   src_rate_reg, out_rate_reg;
    logic [CHAN_W-1:0]   src_ch_reg, out_ch_reg;
    logic [FACTOR_W-1:0] factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_rate_reg <= RATE_W'(16000);
            out_rate_reg <= RATE_W'(48000);
            src_ch_reg   <= CHAN_W'(1);
            out_ch_reg   <= CHAN_W'(2);
            factor_reg   <= FACTOR_W'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_RATE: src_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_OUT_RATE: out_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_SRC_CH:   src_ch_reg   <= cfg_data[CHAN_W-1:0];
                CFG_OUT_CH:   out_ch_reg   <= cfg_data[CHAN_W-1:0];
                CFG_FACTOR:   factor_reg   <= cfg_data[FACTOR_W-1:0];
                default:      ;
            endcase
        end
    end

    // captured item
    logic [OP_W-1:0]        op_reg;
    logic [STREAM_IN_W-1:0] stream_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   last_reg;
    logic [VOL_W-1:0]       vol_reg;
    logic [RIDX_W-1:0]      ridx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg     <= operation;
            stream_reg <= stream;
            sample_reg <= sample;
            last_reg   <= last;
            vol_reg    <= (volume_q15 > VOL_W'(VOLUME_MAX)) ? VOL_W'(VOLUME_MAX) : volume_q15;
            ridx_reg   <= ring_index;
        end
    end

    logic                stream_ok;
    logic [STREAM_W-1:0] s_idx;
    assign stream_ok = stream_reg < STREAM_IN_W'(NUM_STREAMS);
    assign s_idx     = stream_reg[STREAM_W-1:0];

    // per-stream state
    logic [RING_AW-1:0] wp_reg  [NUM_STREAMS];
    logic [COUNT_W-1:0] cnt_reg [NUM_STREAMS];
    logic [VOL_W-1:0]   vst_reg [NUM_STREAMS];
    logic [TOT_W-1:0]   total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                wp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
                vst_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clr_all)
            begin
                for (int i = 0; i < NUM_STREAMS; i++)
                begin
                    wp_reg[i]  <= '0;
                    cnt_reg[i] <= '0;
                end
            end
            if (cmd.clr_one)
            begin
                wp_reg[s_idx]  <= '0;
                cnt_reg[s_idx] <= '0;
            end
            if (cmd.set_vol)
            begin
                vst_reg[s_idx] <= vol_reg;
            end
            if (cmd.wr)
            begin
                wp_reg[s_idx] <= wp_reg[s_idx] + 1'b1;
            end
            if (cmd.commit)
            begin
                cnt_reg[s_idx] <= cnt_reg[s_idx] + COUNT_W'(total_reg);
                vst_reg[s_idx] <= vol_reg;
            end
        end
    end

    // batch fill; cleared once the batch's result goes out
    logic [FILL_W-1:0] fill_reg;
    logic              fill_room;
    logic              out_free;
    logic              out_valid_reg;
    assign fill_room = fill_reg < FILL_W'(MAX_BATCH_SAMPLES);
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.batch_wr && fill_room)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
        else if (cmd.finish && out_free && op_reg == OP_LOAD && last_reg)
        begin
            fill_reg <= '0;
        end
    end

    // shared divider
    logic [DIV_NW-1:0] div_n, div_q;
    logic [DIV_DW-1:0] div_d;
    logic              div_busy;
    logic [FILL_W-1:0] frames_reg;
    logic [RATEP_W-1:0] rate_prod_reg;
    logic [STEP_W-1:0] step_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_STEP:
            begin
                div_n = DIV_NW'(rate_prod_reg);
                div_d = DIV_DW'(out_rate_reg);
            end
            DIV_OUT:
            begin
                div_n = (DIV_NW'(frames_reg) << 16) + DIV_NW'(step_reg) - DIV_NW'(1);
                div_d = step_reg;
            end
            default:
            begin
                div_n = DIV_NW'(fill_reg);
                div_d = DIV_DW'(src_ch_reg);
            end
        endcase
    end

    lrrq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q)
    );

    logic [FACTOR_W-1:0] factor_cl;
    assign factor_cl = (factor_reg < FACTOR_W'(FACTOR_MIN)) ? FACTOR_W'(FACTOR_MIN) :
                       (factor_reg > FACTOR_W'(FACTOR_MAX)) ? FACTOR_W'(FACTOR_MAX) :
                       factor_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.frames_ld)
        begin
            frames_reg <= div_q[FILL_W-1:0];
        end
        if (cmd.prod_ld)
        begin
            rate_prod_reg <= (RATEP_W'(src_rate_reg) * RATEP_W'(factor_cl)) << 2;
        end
        if (cmd.step_ld)
        begin
            step_reg <= (|div_q[DIV_NW-1:STEP_W]) ? '1 : div_q[STEP_W-1:0];
        end
        if (cmd.total_ld)
        begin
            total_reg <= TOT_W'(div_q[OF_W-1:0]) * TOT_W'(out_ch_reg);
        end
    end

    // interpolation loop
    logic [POS_W-1:0]    pos_reg;
    logic [CHAN_W-1:0]   ch_cnt_reg;
    logic [COUNT_W-1:0]  remain_reg;
    logic [SAMPLE_W-1:0] cur_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [POS_W-17:0]   pos_hi;
    logic                clamp;
    logic [FILL_W-1:0]   frames_m1;
    logic [BATCH_AW-1:0] sf, nf;
    logic [15:0]         frac;
    logic [CHAN_W-1:0]   sc_m1, ch;
    logic [BATCH_AW-1:0] cur_addr, nxt_addr;
    logic [SAMPLE_W-1:0] batch_rdata;

    assign pos_hi    = pos_reg[POS_W-1:16];
    assign clamp     = pos_hi >= (POS_W-16)'(frames_reg);
    assign frames_m1 = frames_reg - 1'b1;
    assign sf        = clamp ? frames_m1[BATCH_AW-1:0] : pos_hi[BATCH_AW-1:0];
    assign nf        = ((FILL_W'(sf) + 1'b1) < frames_reg) ? sf + 1'b1
                                                           : frames_m1[BATCH_AW-1:0];
    assign frac      = clamp ? 16'h0 : pos_reg[15:0];
    assign sc_m1     = src_ch_reg - 1'b1;
    assign ch        = (ch_cnt_reg < sc_m1) ? ch_cnt_reg : sc_m1;
    assign cur_addr  = BATCH_AW'(ADDR_PW'(sf) * ADDR_PW'(src_ch_reg) + ADDR_PW'(ch));
    assign nxt_addr  = BATCH_AW'(ADDR_PW'(nf) * ADDR_PW'(src_ch_reg) + ADDR_PW'(ch));

    lrrq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_BATCH_SAMPLES)
    ) u_batch_ram (
        .clk   (clk),
        .we    (cmd.batch_wr && fill_room),
        .waddr (fill_reg[BATCH_AW-1:0]),
        .wdata (sample_reg),
        .re    (cmd.rd_cur || cmd.rd_nxt),
        .raddr (cmd.rd_nxt ? nxt_addr : cur_addr),
        .rdata (batch_rdata)
    );

    logic signed [SAMPLE_W:0] diff;
    assign diff = $signed({batch_rdata[SAMPLE_W-1], batch_rdata})
                - $signed({cur_reg[SAMPLE_W-1], cur_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.conv_init)
        begin
            pos_reg    <= '0;
            ch_cnt_reg <= '0;
            remain_reg <= total_reg[COUNT_W-1:0];
        end
        else if (cmd.wr)
        begin
            remain_reg <= remain_reg - 1'b1;
            if (ch_cnt_reg == out_ch_reg - 1'b1)
            begin
                ch_cnt_reg <= '0;
                pos_reg    <= pos_reg + POS_W'(step_reg);
            end
            else
            begin
                ch_cnt_reg <= ch_cnt_reg + 1'b1;
            end
        end
        if (cmd.rd_nxt)
        begin
            cur_reg <= batch_rdata;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(diff * $signed({1'b0, frac}));
        end
    end

    // truncate toward zero, then clamp to 16 bits
    logic signed [PROD_W-1:0]   t_sum;
    logic signed [PROD_W-17:0]  v_q;
    logic [SAMPLE_W-1:0]        v_out;

    assign t_sum = $signed({{(PROD_W-SAMPLE_W-16){cur_reg[SAMPLE_W-1]}}, cur_reg, 16'h0})
                 + prod_reg;
    assign v_q   = $signed(t_sum[PROD_W-1:16])
                 + $signed({{(PROD_W-17){1'b0}}, t_sum[PROD_W-1] && (t_sum[15:0] != '0)});
    assign v_out = (v_q > (PROD_W-16)'(32767))  ? SAMPLE_W'(32767) :
                   (v_q < -(PROD_W-16)'(32768)) ? SAMPLE_W'(-32768) :
                   v_q[SAMPLE_W-1:0];

    // rings
    logic [RING_MEM_AW-1:0] ring_base;
    logic [SAMPLE_W-1:0]    ring_rdata;
    assign ring_base = RING_MEM_AW'(s_idx) << RING_AW;

    lrrq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_STREAMS * RING_SAMPLES)
    ) u_ring_ram (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (ring_base | RING_MEM_AW'(wp_reg[s_idx])),
        .wdata (v_out),
        .re    (cmd.ring_rd),
        .raddr (ring_base | RING_MEM_AW'(RING_AW'(ridx_reg))),
        .rdata (ring_rdata)
    );

    // result register; the working status is held apart so a waiting result
    // keeps its own status while the next item is processed
    lrrq_status_t        status_work_reg;
    lrrq_status_t        status_reg;
    logic [QC_W-1:0]     qc_reg;
    logic [VOL_W-1:0]    svol_reg;
    logic [SAMPLE_W-1:0] rsmp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.status_we)
        begin
            status_work_reg <= cmd.status;
        end
        if (cmd.finish && out_free)
        begin
            status_reg <= status_work_reg;
            qc_reg   <= stream_ok ? QC_W'(cnt_reg[s_idx]) : '0;
            svol_reg <= stream_ok ? vst_reg[s_idx] : '0;
            rsmp_reg <= (stream_ok && op_reg == OP_READ) ? ring_rdata : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign queued_count  = qc_reg;
    assign stream_volume = svol_reg;
    assign read_sample   = rsmp_reg;

    // status to the sequencer
    assign sts.op          = op_reg;
    assign sts.last        = last_reg;
    assign sts.stream_ok   = stream_ok;
    assign sts.cfg_bad     = !stream_ok || src_rate_reg == '0 || out_rate_reg == '0
                             || src_ch_reg == '0 || out_ch_reg == '0;
    assign sts.div_busy    = div_busy;
    assign sts.frames_zero = frames_reg == '0;
    assign sts.step_zero   = step_reg == '0;
    assign sts.total_bad   = total_reg == '0 || total_reg > TOT_W'(RING_SAMPLES);
    assign sts.ring_full   = total_reg > (TOT_W'(RING_SAMPLES) - TOT_W'(cnt_reg[s_idx]));
    assign sts.conv_last   = remain_reg == COUNT_W'(1);
    assign sts.out_free    = out_free;

    // never write more ring words than the batch was sized for
    a_wr_remain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> remain_reg != '0)
        else $error("ring write with no samples left");

    // a committed batch always fits the ring
    a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (TOT_W'(cnt_reg[s_idx]) + total_reg) <= TOT_W'(RING_SAMPLES))
        else $error("commit overflows ring");

    // a finished item shows up on the output in the next cycle
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && out_free) |=> out_valid_reg)
        else $error("result not presented");

    // ring words are written only for a valid stream
    a_wr_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr || cmd.commit) |-> stream_ok)
        else $error("ring write for bad stream");
endmodule
`default_nettype wire

/* rtl/core/linear_resampler_ring_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_resampler_ring_queue
// linear interpolation sample rate converter feeding per-stream ring queues
// ----------------------------------------------------------------------------
// usage:
//   item_in carries one operation per transfer: load sample, reset stream,
//   reset all, set volume or read ring word. result_out returns exactly one
//   result per item. cfg writes the five rate, channel and speed registers;
//   it is always ready, and the user must see that it is written only while
//   the block is idle; the block itself does not enforce this. a load marked
//   last runs three passes of the shared divider (frames, step, output
//   frame count), then its checks, then for each output sample reads the
//   current and next frame through the single read port of the batch
//   store, multiplies and writes one ring word.
//   one item is in flight at a time: a new item is taken only once the
//   sequencer is back in idle after finishing the one before.
//   the result register frees the input side: a new item is taken while an
//   earlier result still waits; the sequencer only stalls in its last state
//   when a second result is ready and the receiver holds ready low.
//   reset: config returns to 16 kHz in, 48 kHz out, 1 to 2 channels, unit
//   speed; all rings empty, all volumes zero, batch empty. ring and batch
//   stores are not cleared; ring words are to be read back only where
//   written, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_resampler_ring_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    lrrq_cfg_if.sink       cfg,
    lrrq_item_if.sink      item_in,
    lrrq_result_if.source  result_out
);
    import lrrq_pkg::*;

    lrrq_cmd_t cmd;
    lrrq_sts_t sts;

    // config port never stalls
    assign cfg.ready = 1'b1;

    // sequencer: one state per step of the batch conversion
    lrrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: stores, divider, interpolator and the result register
    lrrq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .operation     (item_in.operation),
        .stream        (item_in.stream),
        .sample        (item_in.sample),
        .last          (item_in.last),
        .volume_q15    (item_in.volume_q15),
        .ring_index    (item_in.ring_index),
        .out_valid     (result_out.valid),
        .out_ready     (result_out.ready),
        .status        (result_out.status),
        .queued_count  (result_out.queued_count),
        .stream_volume (result_out.stream_volume),
        .read_sample   (result_out.read_sample)
    );
endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the linear resampler ring queue: directed and
// random item streams with random stalls on both channels, each result
// checked against an in-bench resampler and ring queue predictor
// ----------------------------------------------------------------------------
module tb_top;
    import lrrq_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int RAND_PER_PHASE = 375;

    typedef struct {
        lrrq_status_t status;
        logic [QC_W-1:0]     count;
        logic [VOL_W-1:0]    volume;
        logic [SAMPLE_W-1:0] word;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lrrq_cfg_if    cfg_bus();
    lrrq_item_if   item_bus();
    lrrq_result_if res_bus();

    linear_resampler_ring_queue u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus.sink),
        .item_in    (item_bus.sink),
        .result_out (res_bus.source)
    );

    always #10 clk = ~clk;

    // predictor copy of the configuration registers
    int unsigned src_rate, out_rate, src_ch, out_ch, speed_q14;

    // predictor copy of the block state
    shortint     batch_mem [MAX_BATCH_SAMPLES];
    int unsigned batch_len;
    shortint     ring_mem [NUM_STREAMS*RING_SAMPLES];
    bit          ring_written [NUM_STREAMS*RING_SAMPLES];
    int unsigned wr_ptr [NUM_STREAMS];
    int unsigned queued [NUM_STREAMS];
    int unsigned volume [NUM_STREAMS];

    outcome_t pending_q[$];
    int       errors = 0;
    bit       calm = 1'b0;
    int       ready_hold = 0;
    int       idle_cycles = 0;

    initial
    begin
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        item_bus.valid = 1'b0;
        item_bus.operation = '0;
        item_bus.stream = '0;
        item_bus.sample = '0;
        item_bus.last = 1'b0;
        item_bus.volume_q15 = '0;
        item_bus.ring_index = '0;
        res_bus.ready = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic lrrq_status_t convert_batch(int unsigned s, int unsigned vol);
        longint unsigned fac, step, frames, ofr, total, pos, sf, nf, frac, ch;
        longint signed cur, nxt, t, v;
        int unsigned base;
        if (s >= NUM_STREAMS || src_rate == 0 || out_rate == 0 || src_ch == 0 || out_ch == 0)
            return STS_INVALID;
        frames = batch_len / src_ch;
        if (frames == 0)
            return STS_INVALID;
        fac = speed_q14;
        if (fac < FACTOR_MIN) fac = FACTOR_MIN;
        if (fac > FACTOR_MAX) fac = FACTOR_MAX;
        step = (longint'(src_rate) * fac * 4) / out_rate;
        if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
        if (step == 0)
            return STS_INVALID;
        ofr = (frames * 65536 + step - 1) / step;
        total = ofr * out_ch;
        if (total == 0 || total > RING_SAMPLES)
            return STS_INVALID;
        if (total > RING_SAMPLES - queued[s])
            return STS_FULL;
        base = s * RING_SAMPLES;
        for (longint unsigned k = 0; k < ofr; k++)
        begin
            pos = k * step;
            sf = pos >> 16;
            if (sf > frames - 1)
            begin
                sf = frames - 1;
                frac = 0;
            end
            else
                frac = pos & 64'hFFFF;
            nf = (sf + 1 < frames) ? sf + 1 : frames - 1;
            for (int unsigned c = 0; c < out_ch; c++)
            begin
                ch = (src_ch == 1) ? 0 : ((c < src_ch - 1) ? c : src_ch - 1);
                cur = batch_mem[sf * src_ch + ch];
                nxt = batch_mem[nf * src_ch + ch];
                t = cur * 65536 + (nxt - cur) * longint'(frac);
                v = t / 65536;
                if (v < -32768) v = -32768;
                if (v > 32767) v = 32767;
                ring_mem[base + wr_ptr[s]] = shortint'(v);
                ring_written[base + wr_ptr[s]] = 1'b1;
                wr_ptr[s] = (wr_ptr[s] + 1) % RING_SAMPLES;
            end
        end
        queued[s] += int'(total);
        volume[s] = vol;
        return STS_QUEUED;
    endfunction

    function automatic outcome_t predict_item(logic [2:0] op, logic [7:0] s,
                                              logic [15:0] smp, logic lst,
                                              logic [15:0] vq, logic [13:0] idx);
        outcome_t    o;
        bit          ok;
        int unsigned vol;
        ok = s < NUM_STREAMS;
        vol = (vq > VOLUME_MAX) ? VOLUME_MAX : vq;
        o.status = STS_TAKEN;
        o.word = '0;
        case (op)
            OP_LOAD:
            begin
                if (batch_len < MAX_BATCH_SAMPLES)
                begin
                    batch_mem[batch_len] = shortint'(smp);
                    batch_len++;
                end
                if (lst)
                begin
                    o.status = convert_batch(s, vol);
                    batch_len = 0;
                end
            end
            OP_RESET_ONE:
                if (ok)
                begin
                    wr_ptr[s] = 0;
                    queued[s] = 0;
                end
                else
                    o.status = STS_INVALID;
            OP_RESET_ALL:
                for (int i = 0; i < NUM_STREAMS; i++)
                begin
                    wr_ptr[i] = 0;
                    queued[i] = 0;
                end
            OP_SET_VOL:
                if (ok) volume[s] = vol; else o.status = STS_INVALID;
            OP_READ:
                if (ok) o.word = ring_mem[s * RING_SAMPLES + idx]; else o.status = STS_INVALID;
            default:
                o.status = STS_INVALID;
        endcase
        o.count = ok ? queued[s][QC_W-1:0] : '0;
        o.volume = ok ? volume[s][VOL_W-1:0] : '0;
        return o;
    endfunction

    // ---------------------------------------------------------------- drivers

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drives one item and returns at the edge of its transfer, valid still high
    task automatic send_item(logic [2:0] op, logic [7:0] s, logic [15:0] smp,
                             logic lst, logic [15:0] vq, logic [13:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.operation <= op;
        item_bus.stream <= s;
        item_bus.sample <= smp;
        item_bus.last <= lst;
        item_bus.volume_q15 <= vq;
        item_bus.ring_index <= idx;
        do @(posedge clk); while (!item_bus.ready);
        pending_q.push_back(predict_item(op, s, smp, lst, vq, idx));
    endtask

    // lower valid and wait until every result is back
    task automatic drain_items();
        item_bus.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(lrrq_cfg_t idx, int unsigned value);
        drain_items();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_SRC_RATE: src_rate = value & 32'h3FFFF;
            CFG_OUT_RATE: out_rate = value & 32'h3FFFF;
            CFG_SRC_CH:   src_ch = value & 32'hF;
            CFG_OUT_CH:   out_ch = value & 32'hF;
            CFG_FACTOR:   speed_q14 = value & 32'h7FFF;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(int unsigned sr, int unsigned orate, int unsigned sc,
                                  int unsigned oc, int unsigned fac);
        write_reg(CFG_SRC_RATE, sr);
        write_reg(CFG_OUT_RATE, orate);
        write_reg(CFG_SRC_CH, sc);
        write_reg(CFG_OUT_CH, oc);
        write_reg(CFG_FACTOR, fac);
    endtask

    // whole batch of n samples, random content, closing on stream s
    task automatic send_batch(int n, logic [7:0] s, logic [15:0] vq);
        for (int i = 0; i < n; i++)
            send_item(OP_LOAD, (i == n - 1) ? s : 8'($urandom), 16'($urandom),
                      i == n - 1, vq, 14'($urandom));
    endtask

    // ring read of an entry already written; falls back to a volume write
    task automatic read_written(logic [7:0] s);
        logic [13:0] idx;
        bit          found;
        found = 1'b0;
        for (int k = 0; k < 24 && !found; k++)
        begin
            idx = (k == 0 && queued[s] != 0) ? 14'((wr_ptr[s] + RING_SAMPLES - 1) % RING_SAMPLES)
                                            : 14'($urandom);
            found = ring_written[s * RING_SAMPLES + idx];
        end
        if (found)
            send_item(OP_READ, s, 16'($urandom), 1'($urandom), 16'($urandom), idx);
        else
            send_item(OP_SET_VOL, s, 16'($urandom), 1'($urandom), 16'($urandom), '0);
    endtask

    task automatic report(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    // ---------------------------------------------------------------- checker

    // receiver stalls
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                ready_hold = pick_gap();
        end
    end

    // every result transfer against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_q.size() == 0)
                report("unexpected result", res_bus.status, -1);
            else
            begin
                want = pending_q.pop_front();
                if (res_bus.status !== want.status)
                    report("status", res_bus.status, want.status);
                if (res_bus.queued_count !== want.count)
                    report("queued_count", res_bus.queued_count, want.count);
                if (res_bus.stream_volume !== want.volume)
                    report("stream_volume", res_bus.stream_volume, want.volume);
                if (res_bus.read_sample !== want.word)
                    report("read_sample", res_bus.read_sample, want.word);
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // every operation, field extremes, bad streams and undefined codes
    task automatic test_operations();
        send_item(OP_SET_VOL, 8'd0, 16'h0000, 1'b0, 16'd0, '0);
        send_item(OP_SET_VOL, 8'd1, 16'hFFFF, 1'b1, 16'd32768, 14'h3FFF);
        send_item(OP_SET_VOL, 8'd2, 16'h8000, 1'b0, 16'hFFFF, '0);
        send_item(OP_SET_VOL, 8'd255, 16'h7FFF, 1'b0, 16'd100, '0);
        send_item(OP_RESET_ONE, 8'd3, '0, 1'b0, '0, '0);
        send_item(OP_RESET_ONE, 8'd4, '0, 1'b0, '0, '0);
        send_item(3'd5, 8'd0, '0, 1'b0, '0, '0);
        send_item(3'd6, 8'd1, '0, 1'b1, '0, '0);
        send_item(3'd7, 8'd128, '0, 1'b0, '0, '0);
        // non-last load on a bad stream is still just taken
        send_item(OP_LOAD, 8'd200, 16'h7FFF, 1'b0, '0, '0);
        send_item(OP_LOAD, 8'd1, 16'h8000, 1'b1, 16'd40000, '0);
        send_item(OP_READ, 8'd1, '0, 1'b0, '0, 14'd0);
        send_item(OP_READ, 8'd1, '0, 1'b0, '0, 14'd3);
        send_item(OP_READ, 8'd9, '0, 1'b0, '0, 14'h3FFF);
        // last sample on a bad stream rejects the batch
        send_item(OP_LOAD, 8'd0, 16'd5, 1'b0, '0, '0);
        send_item(OP_LOAD, 8'd4, 16'd9, 1'b1, 16'd7, '0);
        send_item(OP_LOAD, 8'd3, 16'h1234, 1'b1, 16'd1, '0);
        send_item(OP_RESET_ALL, 8'd77, '0, 1'b0, '0, '0);
        send_item(OP_SET_VOL, 8'd3, '0, 1'b0, 16'd12, '0);
    endtask

    // zero rates and channels, missing frame, clamped factor, step extremes
    task automatic test_config_edges();
        write_reg(CFG_SRC_RATE, 0);
        send_batch(2, 8'd0, 16'd3);
        write_reg(CFG_SRC_RATE, 16000);
        write_reg(CFG_OUT_RATE, 0);
        send_batch(2, 8'd0, 16'd3);
        write_reg(CFG_OUT_RATE, 48000);
        write_reg(CFG_SRC_CH, 0);
        send_batch(2, 8'd1, 16'd3);
        write_reg(CFG_SRC_CH, 2);
        send_batch(1, 8'd1, 16'd3);
        send_batch(3, 8'd1, 16'd3);
        write_reg(CFG_OUT_CH, 0);
        send_batch(2, 8'd2, 16'd3);
        write_reg(CFG_OUT_CH, 15);
        write_reg(CFG_FACTOR, 0);
        send_batch(2, 8'd2, 16'd4);
        write_reg(CFG_FACTOR, 32'h7FFF);
        send_batch(2, 8'd3, 16'd5);
        // step rounds to zero
        write_all_regs(1, 192000, 1, 1, FACTOR_MIN);
        send_batch(2, 8'd0, 16'd6);
        // step saturates at 32 bits
        write_all_regs(32'h3FFFF, 1, 8, 8, FACTOR_MAX);
        send_batch(16, 8'd0, 16'd7);
        write_all_regs(192000, 3, 1, 8, FACTOR_MAX);
        send_batch(5, 8'd1, 16'd8);
    endtask

    // one batch filling a ring exactly, then full and oversize batches
    // step of 1/16 with 8 output channels gives 128 ring words per sample
    task automatic test_ring_limits();
        write_all_regs(3000, 48000, 1, 8, 16384);
        send_item(OP_RESET_ALL, 8'd0, '0, 1'b0, '0, '0);
        send_batch(RING_SAMPLES / 128, 8'd0, 16'd321);
        send_batch(1, 8'd0, 16'd9);
        send_batch(RING_SAMPLES / 128 + 1, 8'd2, 16'd9);
        send_item(OP_READ, 8'd0, '0, 1'b0, '0, 14'h3FFF);
        send_item(OP_READ, 8'd0, '0, 1'b0, '0, 14'd0);
        for (int i = 0; i < 40; i++)
            read_written(8'd0);
    endtask

    task automatic random_phase(int target);
        int         sent;
        int         r;
        logic [7:0] s;
        sent = 0;
        while (sent < target)
        begin
            r = $urandom_range(0, 99);
            s = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            if (r < 55)
            begin
                r = $urandom_range(1, 12);
                send_batch(r, s, 16'($urandom));
                sent += r;
            end
            else
            begin
                if (r < 72)
                begin
                    if (s < NUM_STREAMS) read_written(s);
                    else send_item(OP_READ, s, 16'($urandom), 1'($urandom),
                                   16'($urandom), 14'($urandom));
                end
                else if (r < 82)
                    send_item(OP_SET_VOL, s, 16'($urandom), 1'($urandom),
                              16'($urandom), 14'($urandom));
                else if (r < 88)
                    send_item(OP_RESET_ONE, s, 16'($urandom), 1'($urandom),
                              16'($urandom), 14'($urandom));
                else if (r < 91)
                    send_item(OP_RESET_ALL, s, 16'($urandom), 1'($urandom),
                              16'($urandom), 14'($urandom));
                else
                    send_item(3'($urandom_range(5, 7)), s, 16'($urandom), 1'($urandom),
                              16'($urandom), 14'($urandom));
                sent++;
            end
            if (sent > 100)
                calm = 1'b0;
        end
    endtask

    task automatic test_random();
        random_phase(RAND_PER_PHASE);
        write_all_regs(44100, 48000, 2, 2, FACTOR_MAX);
        calm = 1'b1;
        random_phase(RAND_PER_PHASE);
        write_all_regs(48000, 22050, 8, 1, FACTOR_MIN);
        random_phase(RAND_PER_PHASE);
        write_all_regs(8000, 96000, 3, 8, $urandom_range(FACTOR_MIN, FACTOR_MAX));
        random_phase(RAND_PER_PHASE);
    endtask

    initial
    begin
        src_rate = 16000;
        out_rate = 48000;
        src_ch = 1;
        out_ch = 2;
        speed_q14 = 16384;
        batch_len = 0;
        for (int i = 0; i < NUM_STREAMS; i++)
        begin
            wr_ptr[i] = 0;
            queued[i] = 0;
            volume[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operations();
        test_random();
        test_config_edges();
        test_ring_limits();
        write_all_regs(16000, 48000, 1, 2, 16384);
        random_phase(RAND_PER_PHASE / 4);

        drain_items();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lrrq_pkg.sv
rtl/core/lrrq_if.sv
rtl/core/lrrq_ram.sv
rtl/core/lrrq_div.sv
rtl/core/lrrq_ctrl.sv
rtl/core/lrrq_dp.sv
rtl/core/linear_resampler_ring_queue.sv
bench/tb_top.sv
